### sv/ilsq_pkg.sv
// Shared types, constants and helpers for the integer least-squares search.
`default_nettype none
package ilsq_pkg;
  localparam int MaxDim = 8;
  localparam int MaxSteps = 100000;
  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_FACTOR   = 2'd0,
    OP_VARIANCE = 2'd1,
    OP_ESTIMATE = 2'd2,
    OP_START    = 2'd3
  } op_t;

  localparam logic [1:0] REG_DIMENSION = 2'd0;
  localparam logic [1:0] REG_NODE_LIMIT = 2'd1;
  localparam logic [1:0] REG_INITIAL_BOUND = 2'd2;

  // request to the divider and its answer
  typedef struct packed {
    logic        go;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  // saturate a signed 64-bit value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

### sv/ilsq_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64 by 32 bits.
`default_nettype none
module ilsq_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ilsq_pkg::div_req_t req,
  output ilsq_pkg::div_rsp_t    rsp
);
  logic        running;
  logic        done_r;
  logic [6:0]  count;
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [33:0] diff;

  always_comb begin
    shifted = {rem[31:0], quo[63]};
    diff = {1'b0, shifted} - {2'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      count <= '0;
    end else if (req.go) begin
      running <= 1'b1;
      count <= 7'd64;
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (running) begin
      if (!diff[33]) begin
        rem <= diff[32:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        running <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end
  assign rsp = {done_r, quo};
endmodule
`default_nettype wire

### sv/integer_least_squares_two_best_search.sv
// Top level of the two-best integer least-squares search.
// Load items are taken while idle; busy stays low for them.
// A start item holds busy for a data-dependent time: the estimate at each
// level accumulates one factor column per cycle, each tried candidate with a
// positive variance waits on the divider, then the results stream out.
// rst is synchronous and clears all control; results cannot be stalled.
`default_nettype none
module integer_least_squares_two_best_search (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         operation,
  input  wire logic [2:0]         row,
  input  wire logic [2:0]         column,
  input  wire logic signed [31:0] value,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  output logic                    strobe,
  output logic                    rank,
  output logic [2:0]              index,
  output logic signed [15:0]      integer_value,
  output logic [47:0]             cost,
  output logic                    found,
  output logic                    limit_hit,
  output logic                    last
);
  typedef enum logic [3:0] {
    S_IDLE, S_OPEN, S_EST, S_CENTER, S_TRY, S_RES, S_DIVW, S_ACC, S_EMIT
  } state_t;

  state_t state;
  logic [3:0]  dimension;
  logic [31:0] node_limit;
  logic [47:0] initial_bound;

  logic signed [31:0] factor_mem [64];
  logic signed [31:0] variance_mem [8];
  logic signed [31:0] estimate_mem [8];
  logic signed [15:0] trial_vector [8];
  logic signed [31:0] residual_store [8];
  logic signed [15:0] level_center [8];
  logic               level_direction [8];
  logic [16:0]        level_step [8];
  logic signed [31:0] level_estimate [8];
  logic [47:0]        level_cost [9];
  logic signed [15:0] best_vector [8];
  logic signed [15:0] runner_vector [8];
  logic [47:0] best_cost, runner_cost;
  logic        best_found, runner_found, limit_flag;
  logic [31:0] node_count;
  logic [3:0]  lv;
  logic [3:0]  n_used;
  logic [2:0]  col;
  logic signed [63:0] acc;
  logic signed [31:0] fac_q;
  logic signed [31:0] cand_y;
  logic signed [15:0] cand;
  logic [47:0] step_cost;
  logic        emit_rank;
  logic [2:0]  emit_idx;

  ilsq_pkg::div_req_t dreq;
  ilsq_pkg::div_rsp_t drsp;
  ilsq_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // combinational helpers
  logic signed [63:0] prod;
  logic signed [63:0] prod_fl;
  logic signed [31:0] z_sat;
  logic signed [16:0] center_c;
  logic signed [32:0] z_abs;
  logic [16:0]        k_s;
  logic signed [17:0] off;
  logic signed [17:0] cand_w;
  logic [2:0]         lv3;
  logic [31:0]        mag;
  logic [48:0]        total;
  logic [3:0]         dim_c;

  always_comb begin
    lv3 = lv[2:0];
    prod = fac_q * residual_store[col];
    prod_fl = prod >>> 16;
    z_sat = ilsq_pkg::sat32(acc);
    z_abs = z_sat[31] ? -{z_sat[31], z_sat} : {1'b0, z_sat};
    center_c = z_sat[31] ? -$signed({1'b0, 16'((z_abs + 33'd32768) >> 16)})
                          : $signed({1'b0, 16'((z_abs + 33'd32768) >> 16)});
    if (z_abs > 33'sd2147450879) center_c = z_sat[31] ? -17'sd32768 : 17'sd32767;
    if (!level_step[lv3][0]) begin
      k_s = {1'b0, level_step[lv3][16:1]};
      off = level_direction[lv3] ? -$signed({1'b0, k_s}) : $signed({1'b0, k_s});
    end else begin
      k_s = 17'((18'(level_step[lv3]) + 18'd1) >> 1);
      off = level_direction[lv3] ? $signed({1'b0, k_s}) : -$signed({1'b0, k_s});
    end
    cand_w = 18'(level_center[lv3]) + off;
    mag = cand_y[31] ? 32'(-33'(cand_y)) : 32'(cand_y);
    total = {1'b0, level_cost[lv]} + {1'b0, step_cost};
    if (total > {1'b0, ilsq_pkg::Mask48}) total = {1'b0, ilsq_pkg::Mask48};
    dim_c = (dimension == 4'd0) ? 4'd1 : (dimension > 4'(ilsq_pkg::MaxDim))
          ? 4'(ilsq_pkg::MaxDim) : dimension;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    dreq.go <= 1'b0;
    strobe <= 1'b0;
    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        ilsq_pkg::REG_DIMENSION: dimension <= cfg_data[3:0];
        ilsq_pkg::REG_NODE_LIMIT: node_limit <= cfg_data[31:0];
        ilsq_pkg::REG_INITIAL_BOUND: initial_bound <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      state <= S_IDLE;
      dimension <= 4'd1;
      node_limit <= 32'd1000000;
      initial_bound <= ilsq_pkg::Mask48;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            case (ilsq_pkg::op_t'(operation))
              ilsq_pkg::OP_FACTOR: factor_mem[{row, column}] <= value;
              ilsq_pkg::OP_VARIANCE: variance_mem[row] <= value;
              ilsq_pkg::OP_ESTIMATE: estimate_mem[row] <= value;
              default: begin
                n_used <= dim_c;
                best_cost <= initial_bound;
                runner_cost <= initial_bound;
                best_found <= 1'b0;
                runner_found <= 1'b0;
                limit_flag <= 1'b0;
                node_count <= '0;
                lv <= '0;
                for (int i = 0; i < 8; i++) begin
                  best_vector[i] <= '0;
                  runner_vector[i] <= '0;
                  trial_vector[i] <= '0;
                  residual_store[i] <= '0;
                end
                for (int i = 0; i < 9; i++) level_cost[i] <= '0;
                state <= S_OPEN;
              end
            endcase
          end
        end
        // enter node at level lv
        S_OPEN: begin
          if (node_count >= node_limit) begin
            limit_flag <= 1'b1;
            emit_rank <= 1'b0;
            emit_idx <= '0;
            state <= S_EMIT;
          end else begin
            node_count <= node_count + 32'd1;
            if (lv >= n_used) begin
              if (level_cost[n_used] < best_cost) begin
                runner_cost <= best_cost;
                runner_found <= best_found;
                best_cost <= level_cost[n_used];
                best_found <= 1'b1;
                for (int i = 0; i < 8; i++) begin
                  runner_vector[i] <= best_vector[i];
                  best_vector[i] <= trial_vector[i];
                end
              end else if (level_cost[n_used] < runner_cost) begin
                runner_cost <= level_cost[n_used];
                runner_found <= 1'b1;
                for (int i = 0; i < 8; i++) runner_vector[i] <= trial_vector[i];
              end
              lv <= lv - 4'd1;
              state <= S_TRY;
            end else begin
              acc <= 64'(estimate_mem[lv3]);
              col <= '0;
              fac_q <= factor_mem[{lv3, 3'd0}];
              state <= (lv == 4'd0) ? S_CENTER : S_EST;
            end
          end
        end
        // one factor column per cycle
        S_EST: begin
          acc <= acc + prod_fl;
          col <= col + 3'd1;
          fac_q <= factor_mem[{lv3, col + 3'd1}];
          if ({1'b0, col} + 4'd1 == lv) state <= S_CENTER;
        end
        S_CENTER: begin
          level_estimate[lv3] <= z_sat;
          if (level_cost[lv] >= runner_cost) begin
            if (lv == 4'd0) begin
              emit_rank <= 1'b0;
              emit_idx <= '0;
              state <= S_EMIT;
            end else begin
              lv <= lv - 4'd1;
              state <= S_TRY;
            end
          end else begin
            level_center[lv3] <= center_c[15:0];
            level_direction[lv3] <= (64'(z_sat) >= 64'(center_c) * 64'sd65536);
            level_step[lv3] <= '0;
            state <= S_TRY;
          end
        end
        // pick next candidate of level lv
        S_TRY: begin
          if (level_step[lv3] >= 17'(ilsq_pkg::MaxSteps)) begin
            if (lv == 4'd0) begin
              emit_rank <= 1'b0;
              emit_idx <= '0;
              state <= S_EMIT;
            end else lv <= lv - 4'd1;
          end else begin
            level_step[lv3] <= level_step[lv3] + 17'd1;
            if (cand_w >= -18'sd32768 && cand_w <= 18'sd32767) begin
              cand <= cand_w[15:0];
              cand_y <= ilsq_pkg::sat32(64'(cand_w) * 64'sd65536 -
                                         64'(level_estimate[lv3]));
              state <= S_RES;
            end
          end
        end
        S_RES: begin
          trial_vector[lv3] <= cand;
          residual_store[lv3] <= cand_y;
          if (variance_mem[lv3] > 0) begin
            dreq.dividend <= 64'(mag) * 64'(mag);
            dreq.divisor <= variance_mem[lv3];
            dreq.go <= 1'b1;
            state <= S_DIVW;
          end else begin
            step_cost <= ilsq_pkg::Mask48;
            state <= S_ACC;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            step_cost <= (drsp.quotient > 64'(ilsq_pkg::Mask48)) ? ilsq_pkg::Mask48
                         : drsp.quotient[47:0];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (total[47:0] >= runner_cost) begin
            level_step[lv3] <= 17'(ilsq_pkg::MaxSteps);
            state <= S_TRY;
          end else begin
            level_cost[lv + 4'd1] <= total[47:0];
            lv <= lv + 4'd1;
            state <= S_OPEN;
          end
        end
        // stream both candidates
        S_EMIT: begin
          strobe <= 1'b1;
          rank <= emit_rank;
          index <= emit_idx;
          found <= emit_rank ? runner_found : best_found;
          limit_hit <= limit_flag;
          integer_value <= (emit_rank ? runner_found : best_found)
              ? (emit_rank ? runner_vector[emit_idx] : best_vector[emit_idx]) : 16'sd0;
          cost <= (emit_rank ? runner_found : best_found)
              ? (emit_rank ? runner_cost : best_cost) : 48'd0;
          last <= emit_rank && ({1'b0, emit_idx} + 4'd1 == n_used);
          if ({1'b0, emit_idx} + 4'd1 == n_used) begin
            emit_idx <= '0;
            if (emit_rank) state <= S_IDLE;
            emit_rank <= 1'b1;
          end else emit_idx <= emit_idx + 3'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sim/integer_least_squares_two_best_search_test.sv
// Testbench for the two-best integer least-squares search: table, random loads and starts.
`timescale 1ns / 1ps
`default_nettype none
module integer_least_squares_two_best_search_test;

  localparam int IdleLimit = 300000;
  localparam logic [47:0] FullBound = 48'hFFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] operation;
  logic [2:0] row;
  logic [2:0] column;
  logic signed [31:0] value;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;
  logic strobe;
  logic rank;
  logic [2:0] index;
  logic signed [15:0] integer_value;
  logic [47:0] cost;
  logic found;
  logic limit_hit;
  logic last;

  integer_least_squares_two_best_search u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .row(row), .column(column), .value(value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .rank(rank), .index(index), .integer_value(integer_value),
    .cost(cost), .found(found), .limit_hit(limit_hit), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one emitted candidate element
  typedef struct {
    bit rank;
    bit [2:0] index;
    bit [15:0] ival;
    bit [47:0] cost;
    bit found;
    bit lim;
    bit last;
  } cand_elem_t;

  cand_elem_t pending_elems[$];
  int errors = 0;
  int idle_cycles = 0;

  // ---------------- search predictor state ----------------
  int fac_m[8][8];
  int var_m[8];
  int est_m[8];
  int trial_m[8];
  int resid_m[8];
  int center_m[8];
  bit dir_m[8];
  int unsigned step_m[8];
  int lest_m[8];
  longint unsigned lcost_m[9];
  int best_v[8];
  int runner_v[8];
  longint unsigned best_c;
  longint unsigned runner_c;
  int unsigned nodes;
  bit best_f;
  bit runner_f;
  bit limit_f;
  bit [3:0] dim_cfg;
  bit [31:0] nlimit_cfg;
  bit [47:0] bound_cfg;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // enter a node: -1 limit reached, 0 nothing below, 1 level opened
  function automatic int enter_node(int lv, int n);
    longint z;
    longint c;
    longint unsigned leaf;
    if (nodes >= nlimit_cfg) begin
      limit_f = 1'b1;
      return -1;
    end
    nodes++;
    if (lv >= n) begin
      leaf = lcost_m[n];
      if (leaf < best_c) begin
        runner_c = best_c;
        runner_f = best_f;
        runner_v = best_v;
        best_c = leaf;
        best_f = 1'b1;
        best_v = trial_m;
      end else if (leaf < runner_c) begin
        runner_c = leaf;
        runner_f = 1'b1;
        runner_v = trial_m;
      end
      return 0;
    end
    z = est_m[lv];
    for (int j = 0; j < lv; j++) z += (longint'(fac_m[lv][j]) * longint'(resid_m[j])) >>> 16;
    z = clip32(z);
    lest_m[lv] = int'(z);
    if (lcost_m[lv] >= runner_c) return 0;
    if (z >= 0) c = (z + 32768) >>> 16;
    else c = -((-z + 32768) >>> 16);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    center_m[lv] = int'(c);
    dir_m[lv] = (z >= c * 65536);
    step_m[lv] = 0;
    return 1;
  endfunction

  function automatic void descend(int n);
    int lv;
    int r;
    int unsigned s;
    longint k;
    longint off;
    longint cand;
    longint y;
    longint unsigned mag;
    longint unsigned step_cost;
    longint unsigned total;
    bit down;
    lv = 0;
    r = enter_node(0, n);
    if (r <= 0) return;
    forever begin
      down = 1'b0;
      while (step_m[lv] < ilsq_pkg::MaxSteps) begin
        s = step_m[lv];
        step_m[lv]++;
        if (s[0] == 1'b0) begin
          k = s / 2;
          off = dir_m[lv] ? -k : k;
        end else begin
          k = (s + 1) / 2;
          off = dir_m[lv] ? k : -k;
        end
        cand = longint'(center_m[lv]) + off;
        if (cand < -32768 || cand > 32767) continue;
        y = clip32(cand * 65536 - longint'(lest_m[lv]));
        trial_m[lv] = int'(cand);
        resid_m[lv] = int'(y);
        mag = (y < 0) ? longint'(-y) : y;
        step_cost = (var_m[lv] > 0) ? (mag * mag) / longint'(var_m[lv]) : FullBound;
        if (step_cost > FullBound) step_cost = FullBound;
        total = lcost_m[lv] + step_cost;
        if (total > FullBound) total = FullBound;
        if (total >= runner_c) begin
          step_m[lv] = ilsq_pkg::MaxSteps;
          break;
        end
        lcost_m[lv + 1] = total;
        r = enter_node(lv + 1, n);
        if (r < 0) return;
        if (r > 0) begin
          lv++;
          down = 1'b1;
          break;
        end
      end
      if (!down) begin
        if (lv == 0) return;
        lv--;
      end
    end
  endfunction

  // run a start request and queue its 2*n candidate elements
  function automatic void predict_two_best();
    int n;
    cand_elem_t e;
    n = (dim_cfg < 1) ? 1 : ((dim_cfg > ilsq_pkg::MaxDim) ? ilsq_pkg::MaxDim : int'(dim_cfg));
    best_c = bound_cfg;
    runner_c = bound_cfg;
    best_f = 0;
    runner_f = 0;
    limit_f = 0;
    nodes = 0;
    for (int i = 0; i < 8; i++) begin
      best_v[i] = 0;
      runner_v[i] = 0;
      trial_m[i] = 0;
      resid_m[i] = 0;
    end
    for (int i = 0; i < 9; i++) lcost_m[i] = 0;
    descend(n);
    for (int rk = 0; rk < 2; rk++) begin
      for (int i = 0; i < n; i++) begin
        e.rank = rk[0];
        e.index = i[2:0];
        e.found = rk ? runner_f : best_f;
        e.ival = e.found ? (rk ? runner_v[i][15:0] : best_v[i][15:0]) : 16'd0;
        e.cost = e.found ? (rk ? runner_c[47:0] : best_c[47:0]) : 48'd0;
        e.lim = limit_f;
        e.last = (rk == 1 && i == n - 1);
        pending_elems.push_back(e);
      end
    end
  endfunction

  // update the stores for one accepted request
  function automatic void absorb_request(ilsq_pkg::op_t op, bit [2:0] r, bit [2:0] c, int v);
    case (op)
      ilsq_pkg::OP_FACTOR: fac_m[r][c] = v;
      ilsq_pkg::OP_VARIANCE: var_m[r] = v;
      ilsq_pkg::OP_ESTIMATE: est_m[r] = v;
      default: predict_two_best();
    endcase
  endfunction

  // ---------------- drivers ----------------
  task automatic send_request(ilsq_pkg::op_t op, bit [2:0] r, bit [2:0] c, bit [31:0] v);
    start <= 1'b1;
    operation <= op;
    row <= r;
    column <= c;
    value <= v;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    absorb_request(op, r, c, int'(v));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles == 0) return;
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [47:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ilsq_pkg::REG_DIMENSION: dim_cfg = data[3:0];
      ilsq_pkg::REG_NODE_LIMIT: nlimit_cfg = data[31:0];
      default: bound_cfg = data;
    endcase
    @(posedge clk);
  endtask

  // well-conditioned random contents
  function automatic bit [31:0] mild_factor();
    return 32'($signed($urandom_range(262144)) - 131072);
  endfunction

  function automatic bit [31:0] mild_variance();
    return 32'($urandom_range(300000, 3277));
  endfunction

  function automatic bit [31:0] mild_estimate();
    return 32'($signed($urandom_range(13107200)) - 6553600);
  endfunction

  task automatic fill_stores();
    for (int i = 0; i < 8; i++) begin
      send_request(ilsq_pkg::OP_VARIANCE, i[2:0], 3'($urandom), mild_variance());
      send_request(ilsq_pkg::OP_ESTIMATE, i[2:0], 3'($urandom), mild_estimate());
      for (int j = 0; j < i; j++)
        send_request(ilsq_pkg::OP_FACTOR, i[2:0], j[2:0], mild_factor());
    end
  endtask

  // ---------------- directed table ----------------
  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t kind;
    logic [1:0] code;   // operation or register index
    bit [2:0] r;
    bit [2:0] c;
    bit [47:0] data;
    bit typed;          // start whose outcome is fixed: nothing found
    bit t_lim;
  } table_row_t;

  table_row_t dir_table[$];

  function automatic void add_row(row_kind_t k, logic [1:0] code, bit [2:0] r, bit [2:0] c,
                                  bit [47:0] data, bit typed = 0, bit t_lim = 0);
    table_row_t t;
    t.kind = k;
    t.code = code;
    t.r = r;
    t.c = c;
    t.data = data;
    t.typed = typed;
    t.t_lim = t_lim;
    dir_table.push_back(t);
  endfunction

  task automatic walk_table();
    int n;
    cand_elem_t e;
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_table[i].code, dir_table[i].data);
      end else begin
        send_request(ilsq_pkg::op_t'(dir_table[i].code), dir_table[i].r, dir_table[i].c,
                     dir_table[i].data[31:0]);
        if (dir_table[i].typed) begin
          // replace prediction with the hand-typed outcome
          n = (dim_cfg < 1) ? 1
              : ((dim_cfg > ilsq_pkg::MaxDim) ? ilsq_pkg::MaxDim : int'(dim_cfg));
          repeat (2 * n) void'(pending_elems.pop_back());
          for (int k = 0; k < 2 * n; k++) begin
            e.rank = (k >= n);
            e.index = 3'(k % n);
            e.ival = 0;
            e.cost = 0;
            e.found = 0;
            e.lim = dir_table[i].t_lim;
            e.last = (k == 2 * n - 1);
            pending_elems.push_back(e);
          end
        end
      end
    end
    drain();
  endtask

  // ---------------- result checker ----------------
  always @(negedge clk) begin
    cand_elem_t x;
    if (!rst && strobe) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result rank=%0d index=%0d", $time, rank, index);
        errors++;
      end else begin
        x = pending_elems.pop_front();
        if ({rank, index, integer_value, cost, found, limit_hit, last} !==
            {x.rank, x.index, x.ival, x.cost, x.found, x.lim, x.last}) begin
          $display("%0t: mismatch expected rank=%0d idx=%0d val=%0d cost=%h f=%0d lim=%0d last=%0d",
                   $time, x.rank, x.index, $signed(x.ival), x.cost, x.found, x.lim, x.last);
          $display("%0t:          actual rank=%0d idx=%0d val=%0d cost=%h f=%0d lim=%0d last=%0d",
                   $time, rank, index, integer_value, cost, found, limit_hit, last);
          errors++;
        end
      end
    end
  end

  // watchdog on progress
  always @(negedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int burst;
    int roll;
    ilsq_pkg::op_t op;
    bit [31:0] v;
    rst = 1'b1;
    start = 1'b0;
    operation = ilsq_pkg::OP_FACTOR;
    row = 0;
    column = 0;
    value = 0;
    cfg_we = 1'b0;
    cfg_index = ilsq_pkg::REG_DIMENSION;
    cfg_data = 0;
    dim_cfg = 1;
    nlimit_cfg = 1000000;
    bound_cfg = FullBound;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fill_stores();

    add_row(ROW_CFG, ilsq_pkg::REG_DIMENSION, 0, 0, 48'd0);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0);
    add_row(ROW_CFG, ilsq_pkg::REG_INITIAL_BOUND, 0, 0, 48'd0);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0, 1, 0);
    add_row(ROW_CFG, ilsq_pkg::REG_INITIAL_BOUND, 0, 0, FullBound);
    add_row(ROW_CFG, ilsq_pkg::REG_NODE_LIMIT, 0, 0, 48'd1);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0, 1, 1);
    add_row(ROW_CFG, ilsq_pkg::REG_NODE_LIMIT, 0, 0, 48'hFFFF_FFFF);
    add_row(ROW_CFG, ilsq_pkg::REG_DIMENSION, 0, 0, 48'd3);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 7, 7, 48'hFFFF_FFFF);
    // variance not positive prunes the top level
    add_row(ROW_REQ, ilsq_pkg::OP_VARIANCE, 0, 0, 48'd0);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0, 1, 0);
    add_row(ROW_REQ, ilsq_pkg::OP_VARIANCE, 0, 0, 48'h8000_0000);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0, 1, 0);
    add_row(ROW_REQ, ilsq_pkg::OP_VARIANCE, 0, 0, 48'd65536);
    // estimates at the range ends: centers clamp, candidates go out of range
    add_row(ROW_REQ, ilsq_pkg::OP_ESTIMATE, 0, 0, 48'h7FFF_FFFF);
    add_row(ROW_REQ, ilsq_pkg::OP_ESTIMATE, 1, 0, 48'h8000_0000);
    add_row(ROW_REQ, ilsq_pkg::OP_FACTOR, 1, 0, 48'h8000_0000);
    add_row(ROW_REQ, ilsq_pkg::OP_FACTOR, 2, 1, 48'h7FFF_FFFF);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0);
    add_row(ROW_REQ, ilsq_pkg::OP_ESTIMATE, 0, 0, 48'h0001_8000);
    add_row(ROW_REQ, ilsq_pkg::OP_ESTIMATE, 1, 0, 48'hFFFE_8000);
    add_row(ROW_REQ, ilsq_pkg::OP_FACTOR, 1, 0, 48'h0000_4000);
    add_row(ROW_REQ, ilsq_pkg::OP_FACTOR, 2, 1, 48'hFFFF_C000);
    add_row(ROW_CFG, ilsq_pkg::REG_NODE_LIMIT, 0, 0, 48'd60);
    add_row(ROW_CFG, ilsq_pkg::REG_DIMENSION, 0, 0, 48'd15);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0);
    add_row(ROW_CFG, ilsq_pkg::REG_DIMENSION, 0, 0, 48'd8);
    add_row(ROW_REQ, ilsq_pkg::OP_START, 0, 0, 48'd0);
    walk_table();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(ilsq_pkg::REG_DIMENSION, 48'($urandom_range(15)));
      write_reg(ilsq_pkg::REG_NODE_LIMIT, 48'($urandom_range(120, 1)));
      write_reg(ilsq_pkg::REG_INITIAL_BOUND, ($urandom_range(3) == 0) ?
                {16'($urandom), 32'($urandom)} >> $urandom_range(30) : FullBound);
      burst = 0;
      for (int i = 0; i < 80; i++) begin
        if (ph == 2 && i == 40) drain();
        if (burst == 0) begin
          burst = $urandom_range(20, 1);
          if ($urandom_range(2) != 0) pause_sender($urandom_range(15));
        end
        burst--;
        roll = $urandom_range(99);
        if (roll < 10) op = ilsq_pkg::OP_START;
        else if (roll < 50) op = ilsq_pkg::OP_FACTOR;
        else if (roll < 75) op = ilsq_pkg::OP_VARIANCE;
        else op = ilsq_pkg::OP_ESTIMATE;
        roll = $urandom_range(99);
        case (op)
          ilsq_pkg::OP_FACTOR: v = (roll < 90) ? mild_factor() : $urandom;
          ilsq_pkg::OP_VARIANCE: v = (roll < 85) ? mild_variance() :
                           (roll < 93) ? -32'($urandom_range(65536)) : $urandom;
          ilsq_pkg::OP_ESTIMATE: v = (roll < 90) ? mild_estimate() : $urandom;
          default: v = $urandom;
        endcase
        send_request(op, 3'($urandom), 3'($urandom), v);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_elems.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

### integer_least_squares_two_best_search.f
sv/ilsq_pkg.sv
sv/ilsq_div.sv
sv/integer_least_squares_two_best_search.sv
sim/integer_least_squares_two_best_search_test.sv
